// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sffb_pkg.sv =====
// ----------------------------------------------------------------------------
// sffb_pkg
// Types and constants of the shape fill framebuffer.
// ----------------------------------------------------------------------------
package sffb_pkg;

   localparam int COORD_W = 12;
   localparam int SYM_W   = 8;

   localparam logic [SYM_W-1:0] SPACE_SYMBOL = 8'h20;

   localparam logic [1:0] MODE_RECT   = 2'd0;
   localparam logic [1:0] MODE_CIRCLE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   localparam logic [1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CANVAS_HEIGHT = 2'd1;

   localparam logic [7:0] CANVAS_RESET = 8'd128;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_BOX    = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_SPAN   = 6'b010000,
      ST_READ   = 6'b100000
   } state_type;

endpackage

// ===== sv/sffb_ram.sv =====
// ----------------------------------------------------------------------------
// sffb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sffb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== sv/shape_fill_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// shape_fill_framebuffer_top
// Character framebuffer with rectangle fill, circle fill and pixel read.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to space, one entry per cycle,
// and busy stays high until the sweep is done, so no command is taken before
// then. A read answers from the registered RAM data with a one-cycle rsp_valid
// strobe that cannot be stalled; the receiver must take it. A fill steps through
// the setup states ST_BOX and ST_SQUARE and then over its bounding box clipped
// to the canvas, visiting one pixel per cycle on the single RAM port. Fills give
// no response. Canvas registers may be written at any time via csr_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shape_fill_framebuffer_top #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic signed [8:0] req_origin_x,
   input  logic signed [8:0] req_origin_y,
   input  logic [7:0]        req_extent_x,
   input  logic [7:0]        req_extent_y,
   input  logic [sffb_pkg::SYM_W-1:0] req_pen_symbol,
   output logic              rsp_valid,
   output logic [sffb_pkg::SYM_W-1:0] rsp_pixel_value,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   import sffb_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic signed [COORD_W-1:0] MAXW_C = COORD_W'(MAX_WIDTH);
   localparam logic signed [COORD_W-1:0] MAXH_C = COORD_W'(MAX_HEIGHT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);

   function automatic logic signed [COORD_W-1:0] clip_dim(
      input logic [7:0]                 v,
      input logic signed [COORD_W-1:0]  lim
   );
      logic signed [COORD_W-1:0] ve;
      ve = signed'({{(COORD_W-8){1'b0}}, v});
      return (ve > lim) ? lim : ve;
   endfunction

   state_type state_ff, state_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]    canvas_w_ff, canvas_w_in;
   logic [7:0]    canvas_h_ff, canvas_h_in;

   logic [1:0]              mode_ff, mode_in;
   logic signed [8:0]       ox_ff, ox_in, oy_ff, oy_in;
   logic [7:0]              ex_ff, ex_in, ey_ff, ey_in;
   logic [SYM_W-1:0]        sym_ff, sym_in;
   logic                    rd_on_ff, rd_on_in;

   logic signed [COORD_W-1:0] x0_ff, x0_in, x_last_ff, x_last_in;
   logic signed [COORD_W-1:0] y0_ff, y0_in, y_last_ff, y_last_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic                      empty_ff, empty_in;
   logic [15:0]               r2_ff, r2_in;

   logic signed [9:0] dx_ff, dx_in, dx0_ff, dx0_in, dy_ff, dy_in;
   logic [16:0]       dx2_ff, dx2_in, dx0sq_ff, dx0sq_in, dy2_ff, dy2_in;
   logic [AW-1:0]     addr_ff, addr_in, row_addr_ff, row_addr_in;

   logic signed [COORD_W-1:0] used_w, used_h;
   logic signed [COORD_W-1:0] ox_e, oy_e, ex_e, ey_e;
   logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y, cx0, cx1, cy0, cy1;
   logic signed [COORD_W-1:0] req_ox_e, req_oy_e;
   logic                      req_on;
   logic [AW-1:0]             req_addr;
   logic signed [COORD_W-1:0] dx0_w, dy0_w;
   logic signed [19:0]        dx0_prod, dy0_prod;
   logic [AW-1:0]             first_addr;
   logic [16:0]               dx_step, dy_step;
   logic [17:0]               dist2;
   logic                      covered, col_end, row_end, accept;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [SYM_W-1:0] ram_wdata, ram_rdata;

   sffb_ram #(
      .WIDTH (SYM_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = req_start && !busy;

   assign used_w = clip_dim(canvas_w_ff, MAXW_C);
   assign used_h = clip_dim(canvas_h_ff, MAXH_C);

   // box bounds of the latched command
   assign ox_e = {{(COORD_W-9){ox_ff[8]}}, ox_ff};
   assign oy_e = {{(COORD_W-9){oy_ff[8]}}, oy_ff};
   assign ex_e = signed'({{(COORD_W-8){1'b0}}, ex_ff});
   assign ey_e = signed'({{(COORD_W-8){1'b0}}, ey_ff});

   always_comb begin
      if (mode_ff == MODE_CIRCLE) begin
         lo_x = ox_e - ex_e;
         hi_x = ox_e + ex_e + COORD_W'(1);
         lo_y = oy_e - ex_e;
         hi_y = oy_e + ex_e + COORD_W'(1);
      end else begin
         lo_x = ox_e;
         hi_x = ox_e + ex_e;
         lo_y = oy_e;
         hi_y = oy_e + ey_e;
      end
      cx0 = (lo_x < 0) ? '0 : lo_x;
      cy0 = (lo_y < 0) ? '0 : lo_y;
      cx1 = (hi_x > used_w) ? used_w : hi_x;
      cy1 = (hi_y > used_h) ? used_h : hi_y;
   end

   // read address straight from the request
   assign req_ox_e = {{(COORD_W-9){req_origin_x[8]}}, req_origin_x};
   assign req_oy_e = {{(COORD_W-9){req_origin_y[8]}}, req_origin_y};
   assign req_on   = (req_ox_e >= 0) && (req_ox_e < used_w) &&
                     (req_oy_e >= 0) && (req_oy_e < used_h);
   assign req_addr = AW'(AW'(req_origin_y[7:0]) * ROW_STEP + AW'(req_origin_x[7:0]));

   // start-of-box offsets and squares
   assign dx0_w      = x0_ff - ox_e;
   assign dy0_w      = y0_ff - oy_e;
   assign dx0_prod   = {{10{dx0_w[9]}}, dx0_w[9:0]} * {{10{dx0_w[9]}}, dx0_w[9:0]};
   assign dy0_prod   = {{10{dy0_w[9]}}, dy0_w[9:0]} * {{10{dy0_w[9]}}, dy0_w[9:0]};
   assign first_addr = AW'(AW'(y0_ff[COORD_W-2:0]) * ROW_STEP +
                           AW'(x0_ff[COORD_W-2:0]));

   // (d+1)^2 = d^2 + 2d + 1
   assign dx_step = {{6{dx_ff[9]}}, dx_ff, 1'b1};
   assign dy_step = {{6{dy_ff[9]}}, dy_ff, 1'b1};
   assign dist2   = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign covered = (mode_ff == MODE_RECT) || (dist2 <= {2'b00, r2_ff});
   assign col_end = (x_ff == x_last_ff);
   assign row_end = (y_ff == y_last_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = req_addr;
      ram_wdata = sym_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_ff;
            ram_wdata = SPACE_SYMBOL;
         end
         ST_SPAN: begin
            ram_we   = covered;
            ram_addr = addr_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign rsp_valid       = (state_ff == ST_READ);
   assign rsp_pixel_value = rd_on_ff ? ram_rdata : SPACE_SYMBOL;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      canvas_w_in = canvas_w_ff;
      canvas_h_in = canvas_h_ff;
      mode_in     = mode_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      ex_in       = ex_ff;
      ey_in       = ey_ff;
      sym_in      = sym_ff;
      rd_on_in    = rd_on_ff;
      x0_in       = x0_ff;
      x_last_in   = x_last_ff;
      y0_in       = y0_ff;
      y_last_in   = y_last_ff;
      empty_in    = empty_ff;
      r2_in       = r2_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      dx_in       = dx_ff;
      dx0_in      = dx0_ff;
      dy_in       = dy_ff;
      dx2_in      = dx2_ff;
      dx0sq_in    = dx0sq_ff;
      dy2_in      = dy2_ff;
      addr_in     = addr_ff;
      row_addr_in = row_addr_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_w_in = csr_wdata;
            CSR_CANVAS_HEIGHT: canvas_h_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               ox_in    = req_origin_x;
               oy_in    = req_origin_y;
               ex_in    = req_extent_x;
               ey_in    = req_extent_y;
               sym_in   = req_pen_symbol;
               rd_on_in = req_on;
               case (req_mode)
                  MODE_RECT, MODE_CIRCLE: state_in = ST_BOX;
                  MODE_READ:              state_in = ST_READ;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_BOX: begin
            x0_in     = cx0;
            y0_in     = cy0;
            x_last_in = cx1 - COORD_W'(1);
            y_last_in = cy1 - COORD_W'(1);
            empty_in  = (cx1 <= cx0) || (cy1 <= cy0);
            r2_in     = {8'd0, ex_ff} * {8'd0, ex_ff};
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            dx_in       = dx0_w[9:0];
            dx0_in      = dx0_w[9:0];
            dy_in       = dy0_w[9:0];
            dx2_in      = dx0_prod[16:0];
            dx0sq_in    = dx0_prod[16:0];
            dy2_in      = dy0_prod[16:0];
            x_in        = x0_ff;
            y_in        = y0_ff;
            addr_in     = first_addr;
            row_addr_in = first_addr;
            state_in    = empty_ff ? ST_IDLE : ST_SPAN;
         end
         ST_SPAN: begin
            if (!col_end) begin
               x_in    = x_ff + COORD_W'(1);
               dx_in   = dx_ff + 10'sd1;
               dx2_in  = dx2_ff + dx_step;
               addr_in = addr_ff + AW'(1);
            end else if (!row_end) begin
               x_in        = x0_ff;
               dx_in       = dx0_ff;
               dx2_in      = dx0sq_ff;
               y_in        = y_ff + COORD_W'(1);
               dy_in       = dy_ff + 10'sd1;
               dy2_in      = dy2_ff + dy_step;
               row_addr_in = row_addr_ff + ROW_STEP;
               addr_in     = row_addr_ff + ROW_STEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         canvas_w_ff <= CANVAS_RESET;
         canvas_h_ff <= CANVAS_RESET;
         rd_on_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         canvas_w_ff <= canvas_w_in;
         canvas_h_ff <= canvas_h_in;
         rd_on_ff    <= rd_on_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      sym_ff      <= sym_in;
      x0_ff       <= x0_in;
      x_last_ff   <= x_last_in;
      y0_ff       <= y0_in;
      y_last_ff   <= y_last_in;
      empty_ff    <= empty_in;
      r2_ff       <= r2_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      dx0_ff      <= dx0_in;
      dy_ff       <= dy_in;
      dx2_ff      <= dx2_in;
      dx0sq_ff    <= dx0sq_in;
      dy2_ff      <= dy2_in;
      addr_ff     <= addr_in;
      row_addr_ff <= row_addr_in;
   end

   `ASSERT_NEXT(a_read_answered, clock, reset, accept && (req_mode == MODE_READ), rsp_valid)
   `ASSERT_IMPLY(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !ram_we)
   `ASSERT_IMPLY(a_write_in_store, clock, reset, ram_we, 32'(ram_addr) < DEPTH)
   `ASSERT_IMPLY(a_span_column, clock, reset, state_ff == ST_SPAN, (x_ff >= x0_ff) && (x_ff <= x_last_ff))

endmodule

// ===== bench/shape_fill_framebuffer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shape_fill_framebuffer_top_test
// Drives rectangle fills, circle fills and pixel reads into the framebuffer
// across a range of canvas sizes, keeps its own copy of the picture, and
// compares every read answer with the symbol that copy holds at that spot.
// ----------------------------------------------------------------------------
module shape_fill_framebuffer_top_test;
   import sffb_pkg::*;

   localparam int MAX_W        = 128;
   localparam int MAX_H        = 128;
   localparam int CLEAR_CYCLES = MAX_W * MAX_H;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        mode;
      logic signed [8:0] origin_x;
      logic signed [8:0] origin_y;
      logic [7:0]        extent_x;
      logic [7:0]        extent_y;
      logic [7:0]        pen_symbol;
   } draw_cmd_type;

   logic              clock;
   logic              reset;
   logic              req_start;
   logic              busy;
   logic [1:0]        req_mode;
   logic signed [8:0] req_origin_x;
   logic signed [8:0] req_origin_y;
   logic [7:0]        req_extent_x;
   logic [7:0]        req_extent_y;
   logic [SYM_W-1:0]  req_pen_symbol;
   logic              rsp_valid;
   logic [SYM_W-1:0]  rsp_pixel_value;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;

   logic [7:0] picture [0:MAX_W*MAX_H-1];
   logic [7:0] canvas_w;
   logic [7:0] canvas_h;
   logic [7:0] expected_pixels [$];
   logic [7:0] wanted_pixel;

   int    mismatch_count  = 0;
   int    commands_sent   = 0;
   int    pixels_checked  = 0;
   int    csr_writes      = 0;
   int    last_item_cycles = 0;
   longint cycle_count    = 0;
   longint cycle_allowance = 0;

   shape_fill_framebuffer_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_extent_x    (req_extent_x),
      .req_extent_y    (req_extent_y),
      .req_pen_symbol  (req_pen_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * (CLEAR_CYCLES + cycle_allowance) + 20000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("shape_fill_framebuffer_top test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %h with no read pending", rsp_pixel_value));
         end else begin
            wanted_pixel = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_value !== wanted_pixel)
               report_mismatch($sformatf("pixel_value %h, expected %h",
                                         rsp_pixel_value, wanted_pixel));
         end
      end
   end

   function automatic draw_cmd_type make_cmd(input logic [1:0] mode, input int ox, input int oy,
                                             input int ex, input int ey, input int sym);
      draw_cmd_type c;
      c.mode       = mode;
      c.origin_x   = 9'(ox);
      c.origin_y   = 9'(oy);
      c.extent_x   = 8'(ex);
      c.extent_y   = 8'(ey);
      c.pen_symbol = 8'(sym);
      return c;
   endfunction

   // bounding box clipped to the store, one write per pixel
   function automatic int box_cycles(input draw_cmd_type c);
      int ox, oy, ex, ey, x0, x1, y0, y1;
      ox = $signed(c.origin_x);
      oy = $signed(c.origin_y);
      ex = c.extent_x;
      ey = c.extent_y;
      if (c.mode == MODE_RECT) begin
         x0 = ox;      x1 = ox + ex;
         y0 = oy;      y1 = oy + ey;
      end else if (c.mode == MODE_CIRCLE) begin
         x0 = ox - ex; x1 = ox + ex + 1;
         y0 = oy - ex; y1 = oy + ex + 1;
      end else begin
         return 0;
      end
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > MAX_W) x1 = MAX_W;
      if (y1 > MAX_H) y1 = MAX_H;
      if (x1 <= x0 || y1 <= y0) return 0;
      return (x1 - x0) * (y1 - y0);
   endfunction

   task automatic paint_command(input draw_cmd_type c, output bit answers,
                                output logic [7:0] pixel);
      int ox, oy, ex, ey, w, h, x0, x1, y0, y1, x, y, dx, dy;
      ox = $signed(c.origin_x);
      oy = $signed(c.origin_y);
      ex = c.extent_x;
      ey = c.extent_y;
      w  = (canvas_w > MAX_W) ? MAX_W : canvas_w;
      h  = (canvas_h > MAX_H) ? MAX_H : canvas_h;
      answers = 1'b0;
      pixel   = SPACE_SYMBOL;
      case (c.mode)
         MODE_RECT: begin
            x0 = (ox < 0) ? 0 : ox;
            y0 = (oy < 0) ? 0 : oy;
            x1 = (ox + ex > w) ? w : ox + ex;
            y1 = (oy + ey > h) ? h : oy + ey;
            for (y = y0; y < y1; y++)
               for (x = x0; x < x1; x++)
                  picture[y*MAX_W + x] = c.pen_symbol;
         end
         MODE_CIRCLE: begin
            x0 = (ox - ex < 0) ? 0 : ox - ex;
            y0 = (oy - ex < 0) ? 0 : oy - ex;
            x1 = (ox + ex + 1 > w) ? w : ox + ex + 1;
            y1 = (oy + ex + 1 > h) ? h : oy + ex + 1;
            for (y = y0; y < y1; y++) begin
               dy = y - oy;
               for (x = x0; x < x1; x++) begin
                  dx = x - ox;
                  if (dx*dx + dy*dy <= ex*ex)
                     picture[y*MAX_W + x] = c.pen_symbol;
               end
            end
         end
         MODE_READ: begin
            answers = 1'b1;
            if (ox >= 0 && ox < w && oy >= 0 && oy < h)
               pixel = picture[oy*MAX_W + ox];
         end
         default: ;
      endcase
   endtask

   task automatic send_command(input draw_cmd_type c);
      bit         answers;
      logic [7:0] pixel;
      @(negedge clock);
      req_start      = 1'b1;
      req_mode       = c.mode;
      req_origin_x   = c.origin_x;
      req_origin_y   = c.origin_y;
      req_extent_x   = c.extent_x;
      req_extent_y   = c.extent_y;
      req_pen_symbol = c.pen_symbol;
      do @(posedge clock); while (busy);
      paint_command(c, answers, pixel);
      if (answers) expected_pixels = {expected_pixels, pixel};
      commands_sent++;
      last_item_cycles = box_cycles(c) + 8;
      cycle_allowance += last_item_cycles;
   endtask

   task automatic idle_sender(input int gap);
      @(negedge clock);
      req_start = 1'b0;
      repeat (gap - 1) @(negedge clock);
      cycle_allowance += gap;
   endtask

   task automatic drain_reads();
      @(negedge clock);
      req_start = 1'b0;
      while (expected_pixels.size() > 0) @(negedge clock);
   endtask

   // a fill gives no answer, so give the last one time to finish too
   task automatic wait_idle();
      drain_reads();
      repeat (last_item_cycles + 8) @(negedge clock);
      cycle_allowance += last_item_cycles + 8;
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_CANVAS_WIDTH) canvas_w = value;
      else if (index == CSR_CANVAS_HEIGHT) canvas_h = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_canvas(input logic [7:0] w, input logic [7:0] h);
      wait_idle();
      write_csr(CSR_CANVAS_WIDTH, w);
      write_csr(CSR_CANVAS_HEIGHT, h);
   endtask

   function automatic draw_cmd_type random_command();
      draw_cmd_type c;
      int w, h, pick;
      w    = (canvas_w > MAX_W) ? MAX_W : canvas_w;
      h    = (canvas_h > MAX_H) ? MAX_H : canvas_h;
      pick = $urandom_range(0, 99);
      c.mode = (pick < 35) ? MODE_RECT : (pick < 60) ? MODE_CIRCLE :
               (pick < 96) ? MODE_READ : MODE_UNUSED;
      if ($urandom_range(0, 9) == 0) c.origin_x = 9'($urandom_range(0, 511));
      else c.origin_x = 9'(int'($urandom_range(0, w + 15)) - 8);
      if ($urandom_range(0, 9) == 0) c.origin_y = 9'($urandom_range(0, 511));
      else c.origin_y = 9'(int'($urandom_range(0, h + 15)) - 8);
      c.extent_x   = 8'($urandom_range(0, 255));
      c.extent_y   = 8'($urandom_range(0, 255));
      c.pen_symbol = 8'($urandom_range(0, 255));
      // keep most fills small, the odd one spans the whole range
      if ($urandom_range(0, 15) != 0) begin
         if (c.mode == MODE_RECT) begin
            c.extent_x = 8'($urandom_range(0, 20));
            c.extent_y = 8'($urandom_range(0, 20));
         end else if (c.mode == MODE_CIRCLE) begin
            c.extent_x = 8'($urandom_range(0, 10));
         end
      end
      return c;
   endfunction

   task automatic test_reset_contents();
      send_command(make_cmd(MODE_READ, 0, 0, 0, 0, 0));
      send_command(make_cmd(MODE_READ, 127, 127, 255, 255, 255));
      send_command(make_cmd(MODE_READ, -256, 255, 0, 0, 0));
   endtask

   task automatic test_rectangles();
      send_command(make_cmd(MODE_RECT, 0, 0, 255, 255, 8'hFF));
      send_command(make_cmd(MODE_RECT, 5, 5, 0, 10, 8'h41));
      send_command(make_cmd(MODE_RECT, 5, 5, 10, 0, 8'h42));
      send_command(make_cmd(MODE_RECT, -3, -3, 6, 6, 8'h00));
      send_command(make_cmd(MODE_READ, 2, 2, 0, 0, 0));
      send_command(make_cmd(MODE_READ, 5, 5, 0, 0, 0));
   endtask

   task automatic test_circles();
      send_command(make_cmd(MODE_CIRCLE, 10, 10, 0, 0, 8'h43));
      send_command(make_cmd(MODE_READ, 10, 10, 0, 0, 0));
      send_command(make_cmd(MODE_READ, 11, 10, 0, 0, 0));
      send_command(make_cmd(MODE_CIRCLE, -256, -256, 255, 255, 8'h55));
      send_command(make_cmd(MODE_CIRCLE, -5, 20, 7, 0, 8'h44));
      send_command(make_cmd(MODE_READ, 0, 20, 0, 0, 0));
   endtask

   task automatic test_unused_mode();
      send_command(make_cmd(MODE_UNUSED, 0, 0, 255, 255, 8'h99));
      send_command(make_cmd(MODE_READ, 1, 1, 0, 0, 0));
   endtask

   task automatic test_canvas_limits();
      set_canvas(8'd0, 8'd128);
      send_command(make_cmd(MODE_RECT, 0, 0, 10, 10, 8'h5A));
      send_command(make_cmd(MODE_READ, 0, 0, 0, 0, 0));
      set_canvas(8'd255, 8'd1);
      send_command(make_cmd(MODE_RECT, 0, 0, 255, 255, 8'hA5));
      send_command(make_cmd(MODE_READ, 0, 1, 0, 0, 0));
      set_canvas(8'd1, 8'd1);
      send_command(make_cmd(MODE_CIRCLE, 0, 0, 3, 0, 8'h51));
      set_canvas(CANVAS_RESET, CANVAS_RESET);
      send_command(make_cmd(MODE_READ, 0, 0, 0, 0, 0));
      send_command(make_cmd(MODE_READ, 127, 0, 0, 0, 0));
      send_command(make_cmd(MODE_READ, 0, 1, 0, 0, 0));
   endtask

   task automatic test_random_traffic();
      int burst_left, phase, n;
      burst_left = $urandom_range(1, 16);
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_canvas(8'd128, 8'd128);
            1: set_canvas(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
            2: set_canvas(8'd255, 8'($urandom_range(129, 255)));
            3: set_canvas(8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)));
            default: set_canvas(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         for (n = 0; n < 100; n++) begin
            if (phase == 1 && n == 50) drain_reads();
            send_command(random_command());
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
            end
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_start      = 1'b0;
      req_mode       = MODE_RECT;
      req_origin_x   = '0;
      req_origin_y   = '0;
      req_extent_x   = '0;
      req_extent_y   = '0;
      req_pen_symbol = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_CANVAS_WIDTH;
      csr_wdata      = '0;
      canvas_w       = CANVAS_RESET;
      canvas_h       = CANVAS_RESET;
      foreach (picture[i]) picture[i] = SPACE_SYMBOL;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_contents();
      test_rectangles();
      test_circles();
      test_unused_mode();
      test_canvas_limits();
      test_random_traffic();

      drain_reads();
      repeat (32) @(negedge clock);
      if (expected_pixels.size() > 0)
         report_mismatch($sformatf("%0d reads never answered", expected_pixels.size()));

      $display("Sent %0d commands, compared %0d pixel reads, made %0d canvas writes",
               commands_sent, pixels_checked, csr_writes);
      $display("Canvas ran from empty to saturated; fills clipped on every edge");
      if (mismatch_count == 0) begin
         $display("shape_fill_framebuffer_top test passed");
      end else begin
         $display("shape_fill_framebuffer_top test failed");
      end
      $finish;
   end

endmodule
